FILE: hdl/tbs_pkg.sv
package tbs_pkg;

	// input command codes (tuser)
	typedef enum logic [1:0] {
		CMD_WRITE    = 2'd0,
		CMD_NEAREST  = 2'd1,
		CMD_BILINEAR = 2'd2
	} cmd_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;

	localparam int SIZE_W     = 9;
	localparam int CHAN_W     = 8;
	localparam int TEXEL_W    = 24;
	localparam int OUT_CHAN_W = 16;
	localparam int OUT_W      = 48;

	// result queue; the top level reserves a slot per accepted fetch
	localparam int OUT_FIFO_DEPTH = 8;
	localparam int OUT_FIFO_PTR_W = 3;
	localparam int OUT_FIFO_CNT_W = 4;

	// tag that travels with every texel read
	typedef struct packed {
		logic valid;
		logic hfirst;	// first texel of a row pair
		logic hlast;	// last texel of a row pair
		logic vfirst;	// first row of the item
		logic vlast;	// last row: result completes
	} rd_tag_t;

endpackage

FILE: hdl/tbs_ram.sv
module tbs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AddrW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AddrW-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: hdl/tbs_blend.sv
module tbs_blend #(
	parameter int COORD_FRAC_BITS = 16,
	localparam int WtW = COORD_FRAC_BITS + 1,
	localparam int PrW = COORD_FRAC_BITS + 9,
	localparam int VpW = 2 * COORD_FRAC_BITS + 10,
	localparam int ResLo = 2 * COORD_FRAC_BITS - 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tbs_pkg::rd_tag_t             rd_tag,
	input  logic [WtW-1:0]               rd_wx,
	input  logic [WtW-1:0]               rd_wy,
	input  logic [tbs_pkg::TEXEL_W-1:0]  rd_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tbs_pkg::OUT_W-1:0]    out_data
);

	// stage 1: texel channel times horizontal weight
	tbs_pkg::rd_tag_t tag_s1;
	logic [PrW-1:0]   prod_s1 [3];
	logic [WtW-1:0]   wy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= rd_tag;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			prod_s1[c] <= PrW'(rd_data[c*tbs_pkg::CHAN_W +: tbs_pkg::CHAN_W]) * PrW'(rd_wx);
		end
		wy_s1 <= rd_wy;
	end

	// stage 2: row sum
	logic           valid_s2, vfirst_s2, vlast_s2;
	logic [PrW-1:0] hs_s2 [3];
	logic [WtW-1:0] wy_s2;
	logic [PrW-1:0] hacc_q [3];
	logic [PrW-1:0] hs_d [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			hs_d[c] = (tag_s1.hfirst ? '0 : hacc_q[c]) + prod_s1[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			vfirst_s2 <= 1'b0;
			vlast_s2  <= 1'b0;
		end else begin
			valid_s2  <= tag_s1.valid && tag_s1.hlast;
			vfirst_s2 <= tag_s1.vfirst;
			vlast_s2  <= tag_s1.vlast;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid && !tag_s1.hlast) begin
			hacc_q <= prod_s1;
		end
		hs_s2 <= hs_d;
		wy_s2 <= wy_s1;
	end

	// stage 3: row sum times vertical weight
	logic           valid_s3, vfirst_s3, vlast_s3;
	logic [VpW-1:0] vp_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			vfirst_s3 <= 1'b0;
			vlast_s3  <= 1'b0;
		end else begin
			valid_s3  <= valid_s2;
			vfirst_s3 <= vfirst_s2;
			vlast_s3  <= vlast_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			vp_s3[c] <= VpW'(hs_s2[c]) * VpW'(wy_s2);
		end
	end

	// column sum, scale, push into the result queue
	logic [VpW-1:0] vacc_q [3];
	logic [VpW-1:0] vsum [3];
	logic           push;
	logic [tbs_pkg::OUT_W-1:0] push_data;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			vsum[c] = (vfirst_s3 ? '0 : vacc_q[c]) + vp_s3[c];
			push_data[c*tbs_pkg::OUT_CHAN_W +: tbs_pkg::OUT_CHAN_W] =
				vsum[c][ResLo +: tbs_pkg::OUT_CHAN_W];
		end
		push = valid_s3 && vlast_s3;
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && !vlast_s3) begin
			vacc_q <= vp_s3;
		end
	end

	// result queue
	logic [tbs_pkg::OUT_W-1:0]          fifo_q [tbs_pkg::OUT_FIFO_DEPTH];
	logic [tbs_pkg::OUT_FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tbs_pkg::OUT_FIFO_CNT_W-1:0] cnt_q;
	logic                               pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = fifo_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/texture_bilinear_sampler_unit.sv
// Texel store with write, nearest and bilinear fetch. Every word on the input stream is one
// command (tuser): a write converts three intensities (10 fraction bits) to bytes and stores
// them at pixel_x, pixel_y; it returns nothing. A nearest fetch returns the texel at the
// rounded, clamped coordinates; a bilinear fetch blends the four neighbours with exact
// weights. Each fetch returns one output word, channels as byte value times 256. The texel
// memory is a single port and does at most one access per cycle: a bilinear fetch makes its
// four reads in turn, and a write, a nearest fetch or an unused command takes a single slot.
// A fetch's word passes the scale and address stages, the texel read and the blend stages
// before it enters the result queue. Texels come up undefined after reset; there is no
// clearing pass, so fetch only texels that were written. Size registers are to be written
// through the cfg port only while the block is idle, which the block does not enforce; 0
// acts as 1 and values above the store size act as the store size.
module texture_bilinear_sampler_unit #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int COORD_FRAC_BITS = 16,
	localparam int CoordW = COORD_FRAC_BITS + 1,
	localparam int SDataW = ((2 * CoordW + 2 * 8 + 3 * 12 + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbs_pkg::SIZE_W-1:0]     cfg_data,
	// command stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// low to high: coord_u, coord_v, pixel_x, pixel_y, write_red, write_green, write_blue
	input  logic [SDataW-1:0]              s_axis_tdata,
	// command
	input  logic [1:0]                     s_axis_tuser,
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// low to high: red_out, green_out, blue_out
	output logic [tbs_pkg::OUT_W-1:0]      m_axis_tdata
);

	localparam int F       = COORD_FRAC_BITS;
	localparam int WtW     = F + 1;
	localparam int PW      = CoordW + tbs_pkg::SIZE_W;	// coordinate times size
	localparam int IdxW    = tbs_pkg::SIZE_W + 2;		// scaled index, room for round-up
	localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = $clog2(Depth);
	localparam int OffV    = CoordW;
	localparam int OffX    = 2 * CoordW;
	localparam int OffY    = OffX + 8;
	localparam int OffR    = OffY + 8;
	localparam int OffG    = OffR + 12;
	localparam int OffB    = OffG + 12;
	localparam logic [WtW-1:0] WtOne = {1'b1, {F{1'b0}}};
	localparam logic [PW:0]    Half  = (PW + 1)'(1) << (F - 1);
	localparam logic [1:0]     LastStep = 2'd3;

	function automatic logic [tbs_pkg::SIZE_W-1:0] eff_size(
		input logic [tbs_pkg::SIZE_W-1:0] r, input int lim);
		logic [tbs_pkg::SIZE_W-1:0] e;
		if (r == '0) begin
			e = tbs_pkg::SIZE_W'(1);
		end else if (32'(r) > lim) begin
			e = tbs_pkg::SIZE_W'(lim);
		end else begin
			e = r;
		end
		return e;
	endfunction

	// intensity with 10 fraction bits -> byte, times 255, truncate, saturate
	function automatic logic [7:0] to_byte(input logic [11:0] c);
		logic [19:0] p;
		p = 20'(c) * 20'd255;
		return (p[19:10] > 10'd255) ? 8'hFF : p[17:10];
	endfunction

	function automatic logic [IdxW-1:0] clamp_idx(
		input logic [IdxW-1:0] i, input logic [tbs_pkg::SIZE_W-1:0] lim);
		return (i >= IdxW'(lim)) ? IdxW'(lim) - 1'b1 : i;
	endfunction

	function automatic logic [AW-1:0] tex_addr(input logic [IdxW-1:0] x, input logic [IdxW-1:0] y);
		return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
	endfunction

	// ---------------------------------------------------------------- configuration
	logic [tbs_pkg::SIZE_W-1:0] eff_w_q, eff_h_q;

	assign cfg_ready = 1'b1;

	// size registers hold the clamped value; to be written only while idle, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= eff_size(9'd256, MAX_WIDTH);
			eff_h_q <= eff_size(9'd256, MAX_HEIGHT);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tbs_pkg::CFG_TEX_WIDTH:  eff_w_q <= eff_size(cfg_data, MAX_WIDTH);
				tbs_pkg::CFG_TEX_HEIGHT: eff_h_q <= eff_size(cfg_data, MAX_HEIGHT);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- stage 1: scale
	logic [CoordW-1:0] in_u, in_v;
	logic [7:0]        in_x, in_y;
	logic              in_accept, in_fetch;

	assign in_u = s_axis_tdata[0 +: CoordW];
	assign in_v = s_axis_tdata[OffV +: CoordW];
	assign in_x = s_axis_tdata[OffX +: 8];
	assign in_y = s_axis_tdata[OffY +: 8];

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign in_fetch  = (tbs_pkg::cmd_t'(s_axis_tuser) == tbs_pkg::CMD_NEAREST) ||
	                   (tbs_pkg::cmd_t'(s_axis_tuser) == tbs_pkg::CMD_BILINEAR);

	logic                  valid_s1;
	tbs_pkg::cmd_t         cmd_s1;
	logic [PW-1:0]         su_s1, sv_s1;
	logic                  wr_ok_s1;
	logic [AW-1:0]         waddr_s1;
	logic [tbs_pkg::TEXEL_W-1:0] wdata_s1;

	logic valid_s2, done_s2, free_s2, move_s1, free_s1;

	assign move_s1 = valid_s1 && free_s2;
	assign free_s1 = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1   <= tbs_pkg::cmd_t'(s_axis_tuser);
			su_s1    <= PW'(in_u) * PW'(eff_w_q);
			sv_s1    <= PW'(in_v) * PW'(eff_h_q);
			// writes outside the store are dropped
			wr_ok_s1 <= (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT);
			waddr_s1 <= AW'(in_y) * AW'(MAX_WIDTH) + AW'(in_x);
			wdata_s1 <= {to_byte(s_axis_tdata[OffB +: 12]),
			             to_byte(s_axis_tdata[OffG +: 12]),
			             to_byte(s_axis_tdata[OffR +: 12])};
		end
	end

	// ---------------------------------------------------------------- stage 2: addresses
	logic [PW:0]     near_u, near_v;
	logic [IdxW-1:0] nx, ny, bx0, by0, bx1, by1;
	logic [AW-1:0]   addr_d [4];
	logic [WtW-1:0]  wx0_d, wx1_d, wy0_d, wy1_d;

	always_comb begin
		// nearest: round half up, then clamp
		near_u = (PW + 1)'(su_s1) + Half;
		near_v = (PW + 1)'(sv_s1) + Half;
		nx = clamp_idx(near_u[PW:F], eff_w_q);
		ny = clamp_idx(near_v[PW:F], eff_h_q);
		// bilinear: floor and its right/lower neighbours, each clamped
		bx0 = clamp_idx(IdxW'(su_s1[PW-1:F]), eff_w_q);
		by0 = clamp_idx(IdxW'(sv_s1[PW-1:F]), eff_h_q);
		bx1 = clamp_idx(IdxW'(su_s1[PW-1:F]) + 1'b1, eff_w_q);
		by1 = clamp_idx(IdxW'(sv_s1[PW-1:F]) + 1'b1, eff_h_q);

		addr_d[0] = tex_addr(bx0, by0);
		addr_d[1] = tex_addr(bx1, by0);
		addr_d[2] = tex_addr(bx0, by1);
		addr_d[3] = tex_addr(bx1, by1);
		wx0_d = WtOne - WtW'(su_s1[F-1:0]);
		wx1_d = WtW'(su_s1[F-1:0]);
		wy0_d = WtOne - WtW'(sv_s1[F-1:0]);
		wy1_d = WtW'(sv_s1[F-1:0]);

		case (cmd_s1)
			tbs_pkg::CMD_WRITE: begin
				addr_d[0] = waddr_s1;
			end
			tbs_pkg::CMD_NEAREST: begin
				// one read with unit weights through the same blend path
				addr_d[0] = tex_addr(nx, ny);
				wx0_d     = WtOne;
				wy0_d     = WtOne;
			end
			default: ;
		endcase
	end

	tbs_pkg::cmd_t               cmd_s2;
	logic [AW-1:0]               addr_s2 [4];
	logic [WtW-1:0]              wx0_s2, wx1_s2, wy0_s2, wy1_s2;
	logic                        wr_ok_s2;
	logic [tbs_pkg::TEXEL_W-1:0] wdata_s2;
	logic [1:0]                  step_q;
	logic                        last_step;

	assign done_s2 = valid_s2 && last_step;
	assign free_s2 = !valid_s2 || done_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			step_q   <= '0;
		end else begin
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (done_s2) begin
				valid_s2 <= 1'b0;
			end
			if (done_s2) begin
				step_q <= '0;
			end else if (valid_s2) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			cmd_s2   <= cmd_s1;
			addr_s2  <= addr_d;
			wx0_s2   <= wx0_d;
			wx1_s2   <= wx1_d;
			wy0_s2   <= wy0_d;
			wy1_s2   <= wy1_d;
			wr_ok_s2 <= wr_ok_s1;
			wdata_s2 <= wdata_s1;
		end
	end

	// ---------------------------------------------------------------- memory issue
	// At most one access per cycle, in command order, so a fetch after a write always sees it.
	logic                        mem_en, mem_we;
	logic [AW-1:0]               mem_addr;
	logic [tbs_pkg::TEXEL_W-1:0] mem_rdata;
	tbs_pkg::rd_tag_t            tag_d, rd_tag_q;
	logic [WtW-1:0]              wx_d, wy_d, rd_wx_q, rd_wy_q;

	assign mem_addr = addr_s2[step_q];

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		tag_d     = '0;
		wx_d      = wx0_s2;
		wy_d      = wy0_s2;
		last_step = 1'b1;
		if (valid_s2) begin
			unique case (cmd_s2)
				tbs_pkg::CMD_WRITE: begin
					mem_en = wr_ok_s2;
					mem_we = 1'b1;
				end
				tbs_pkg::CMD_NEAREST: begin
					mem_en = 1'b1;
					tag_d  = '{valid: 1'b1, hfirst: 1'b1, hlast: 1'b1,
					           vfirst: 1'b1, vlast: 1'b1};
				end
				tbs_pkg::CMD_BILINEAR: begin
					// steps: top-left, top-right, bottom-left, bottom-right
					mem_en       = 1'b1;
					last_step    = (step_q == LastStep);
					tag_d.valid  = 1'b1;
					tag_d.hfirst = !step_q[0];
					tag_d.hlast  = step_q[0];
					tag_d.vfirst = !step_q[1];
					tag_d.vlast  = (step_q == LastStep);
					wx_d         = step_q[0] ? wx1_s2 : wx0_s2;
					wy_d         = step_q[1] ? wy1_s2 : wy0_s2;
				end
				default: ;
			endcase
		end
	end

	tbs_ram #(
		.WIDTH (tbs_pkg::TEXEL_W),
		.DEPTH (Depth)
	) u_texels (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (wdata_s2),
		.rdata (mem_rdata)
	);

	// tag lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_q <= '0;
		end else begin
			rd_tag_q <= tag_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_wx_q <= wx_d;
		rd_wy_q <= wy_d;
	end

	tbs_blend #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_tag    (rd_tag_q),
		.rd_wx     (rd_wx_q),
		.rd_wy     (rd_wy_q),
		.rd_data   (mem_rdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// ---------------------------------------------------------------- result slots
	// Every accepted fetch holds a slot in the result queue until its word leaves,
	// so the blend pipeline never has to stall.
	logic [tbs_pkg::OUT_FIFO_CNT_W-1:0] credit_q;
	logic                               take, give;

	assign take = in_accept && in_fetch;
	assign give = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = free_s1 &&
	                       (credit_q < tbs_pkg::OUT_FIFO_CNT_W'(tbs_pkg::OUT_FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({take, give})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// ---------------------------------------------------------------- checks
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= tbs_pkg::OUT_FIFO_CNT_W'(tbs_pkg::OUT_FIFO_DEPTH))
		else $error("result slot count above queue depth");

	a_result_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (credit_q != '0))
		else $error("result waiting without a reserved slot");

	a_bilinear_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (cmd_s2 == tbs_pkg::CMD_BILINEAR) && (step_q != LastStep)) |=>
		(valid_s2 && (cmd_s2 == tbs_pkg::CMD_BILINEAR) &&
		 (step_q == 2'($past(step_q) + 2'd1))))
		else $error("bilinear fetch left the issue stage early");

	a_tag_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_tag_q.valid |-> $past(mem_en && !mem_we))
		else $error("read tag without a memory read");

endmodule

FILE: bench/texture_bilinear_sampler_unit_tb.sv
`timescale 1ns / 1ps

module texture_bilinear_sampler_unit_tb;

	// geometry of the store under test (matches the instance parameters)
	localparam int TEX_MAX   = 256;
	localparam int FRAC_BITS = 16;
	localparam int CoordW    = FRAC_BITS + 1;
	localparam int SDataW    = ((2 * CoordW + 2 * 8 + 3 * 12 + 7) / 8) * 8;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int IDLE_PCT      = 6;
	localparam int HOLD_CYCLES   = 400;	// long receiver hold-off
	localparam int SETTLE_CYCLES = 30;	// longer than the pipeline latency
	localparam int CYCLE_LIMIT   = 500000;

	// command 3 is not decoded by the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// register indexes with no register behind them
	localparam logic [tbs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [tbs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	// one command word, fields as the block sees them
	typedef struct packed {
		logic [1:0]  cmd;
		logic [16:0] u;
		logic [16:0] v;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [11:0] r;
		logic [11:0] g;
		logic [11:0] b;
	} tex_item_t;

	// the four texels a fetch blends and their weights;
	// order is (x0,y0), (x1,y0), (x0,y1), (x1,y1)
	typedef struct packed {
		logic [3:0][7:0] x;
		logic [3:0][7:0] y;
		logic [15:0]     fx;
		logic [15:0]     fy;
	} fetch_plan_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [tbs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tbs_pkg::SIZE_W-1:0]     cfg_data = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [SDataW-1:0]              s_axis_tdata = '0;
	logic [1:0]                     s_axis_tuser = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [tbs_pkg::OUT_W-1:0]      m_axis_tdata;

	// shadow of the block: size registers and texel contents
	logic [tbs_pkg::SIZE_W-1:0]  tex_width  = 9'd256;
	logic [tbs_pkg::SIZE_W-1:0]  tex_height = 9'd256;
	logic [tbs_pkg::TEXEL_W-1:0] texel_mem [0:TEX_MAX*TEX_MAX-1];
	bit                          texel_written [0:TEX_MAX*TEX_MAX-1];

	logic [tbs_pkg::OUT_W-1:0] expected_colors [$];
	int mismatches  = 0;
	int cycle_count = 0;
	bit no_idle     = 1'b0;
	int hold_ticket = 0;	// bumped by a test to ask the receiver for a hold-off
	int hold_served = 0;
	int hold_left   = 0;

	texture_bilinear_sampler_unit #(
		.MAX_WIDTH(TEX_MAX),
		.MAX_HEIGHT(TEX_MAX),
		.COORD_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// size in use: 0 reads as 1, anything past the store as the store
	function automatic int unsigned active_size(logic [tbs_pkg::SIZE_W-1:0] reg_val);
		if (reg_val == 0)
			return 1;
		if (reg_val > TEX_MAX)
			return TEX_MAX;
		return 32'(reg_val);
	endfunction

	function automatic logic [7:0] clamp_idx(int unsigned idx, int unsigned lim);
		return (idx >= lim) ? 8'(lim - 1) : 8'(idx);
	endfunction

	// intensity (10 fraction bits) -> byte: times 255, truncate, saturate
	function automatic logic [7:0] to_channel_byte(logic [11:0] level);
		int unsigned scaled;
		scaled = (32'(level) * 255) >> 10;
		return (scaled > 255) ? 8'd255 : scaled[7:0];
	endfunction

	// Texels a fetch touches under the current size. A nearest fetch is a
	// plan with one texel repeated and zero fractions, so the blend below
	// returns that texel unchanged.
	function automatic fetch_plan_t plan_fetch(logic [1:0] cmd, logic [16:0] u,
			logic [16:0] v);
		fetch_plan_t p;
		int unsigned w, h, su, sv, x0, y0;
		w = active_size(tex_width);
		h = active_size(tex_height);
		if (cmd == tbs_pkg::CMD_NEAREST) begin
			// round half up
			x0 = (u * w + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			y0 = (v * h + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			p.x = {4{clamp_idx(x0, w)}};
			p.y = {4{clamp_idx(y0, h)}};
			p.fx = '0;
			p.fy = '0;
		end else begin
			su = u * w;
			sv = v * h;
			x0 = su >> FRAC_BITS;
			y0 = sv >> FRAC_BITS;
			p.fx = su[15:0];
			p.fy = sv[15:0];
			p.x[0] = clamp_idx(x0, w);
			p.x[1] = clamp_idx(x0 + 1, w);
			p.x[2] = clamp_idx(x0, w);
			p.x[3] = clamp_idx(x0 + 1, w);
			p.y[0] = clamp_idx(y0, h);
			p.y[1] = clamp_idx(y0, h);
			p.y[2] = clamp_idx(y0 + 1, h);
			p.y[3] = clamp_idx(y0 + 1, h);
		end
		return p;
	endfunction

	// exact weighted sum, channel kept with 8 fraction bits
	function automatic logic [tbs_pkg::OUT_W-1:0] blend_texels(fetch_plan_t p);
		longint unsigned one;
		longint unsigned wt [4];
		longint unsigned acc;
		logic [tbs_pkg::TEXEL_W-1:0] t;
		logic [tbs_pkg::OUT_W-1:0] color;
		one = longint'(1) << FRAC_BITS;
		wt[0] = (one - p.fx) * (one - p.fy);
		wt[1] = p.fx * (one - p.fy);
		wt[2] = (one - p.fx) * p.fy;
		wt[3] = p.fx * p.fy;
		for (int ch = 0; ch < 3; ch++) begin
			acc = 0;
			for (int k = 0; k < 4; k++) begin
				t = texel_mem[{p.y[k], p.x[k]}];
				acc += wt[k] * t[8*ch +: 8];
			end
			color[16*ch +: 16] = 16'(acc >> (2 * FRAC_BITS - 8));
		end
		return color;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// every field random; callers override what the command uses
	function automatic tex_item_t random_fields();
		tex_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.u = 17'($urandom_range(0, 131071));
		it.v = 17'($urandom_range(0, 131071));
		it.x = 8'($urandom_range(0, 255));
		it.y = 8'($urandom_range(0, 255));
		it.r = 12'($urandom_range(0, 4095));
		it.g = 12'($urandom_range(0, 4095));
		it.b = 12'($urandom_range(0, 4095));
		return it;
	endfunction

	// biased toward zero, exactly one and full scale
	function automatic logic [11:0] pick_intensity();
		case ($urandom_range(0, 9))
			0: return 12'd0;
			1: return 12'd1023;
			2: return 12'd1024;
			3: return 12'd4095;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [16:0] pick_coord();
		case ($urandom_range(0, 19))
			0, 1: return 17'd0;
			2, 3: return 17'd65536;
			4: return 17'd65535;
			5, 6: return 17'($urandom_range(0, 131071));	// up to just under two, often above one
			7, 8, 9: return 17'($urandom_range(0, 16) * 4096);	// often on a texel
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// Offer one word and hold it until taken. The shadow is updated at the
	// edge the word is taken. Valid stays high unless a random gap follows,
	// so back-to-back words never see valid dropped and raised in one step.
	task automatic send_item(tex_item_t it);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.cmd;
		s_axis_tdata <= {2'b00, it.b, it.g, it.r, it.y, it.x, it.v, it.u};
		do @(posedge clk); while (!s_axis_tready);
		case (it.cmd)
			tbs_pkg::CMD_WRITE: begin
				texel_mem[{it.y, it.x}] = {to_channel_byte(it.b),
					to_channel_byte(it.g), to_channel_byte(it.r)};
				texel_written[{it.y, it.x}] = 1'b1;
			end
			tbs_pkg::CMD_NEAREST, tbs_pkg::CMD_BILINEAR:
				expected_colors.insert(expected_colors.size(),
					blend_texels(plan_fetch(it.cmd, it.u, it.v)));
			default: ;
		endcase
		if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_write(logic [7:0] x, logic [7:0] y, logic [11:0] r,
			logic [11:0] g, logic [11:0] b);
		tex_item_t it;
		it = random_fields();
		it.cmd = tbs_pkg::CMD_WRITE;
		it.x = x;
		it.y = y;
		it.r = r;
		it.g = g;
		it.b = b;
		send_item(it);
	endtask

	// texels are undefined until written, so fill in whatever this fetch
	// would touch first
	task automatic send_fetch(logic [1:0] cmd, logic [16:0] u, logic [16:0] v);
		fetch_plan_t p;
		tex_item_t it;
		p = plan_fetch(cmd, u, v);
		for (int k = 0; k < 4; k++) begin
			if (!texel_written[{p.y[k], p.x[k]}])
				send_write(p.x[k], p.y[k], pick_intensity(), pick_intensity(),
					pick_intensity());
		end
		it = random_fields();
		it.cmd = cmd;
		it.u = u;
		it.v = v;
		send_item(it);
	endtask

	task automatic send_random_items(int count);
		tex_item_t it;
		int unsigned w, h, pick;
		for (int n = 0; n < count; n++) begin
			w = active_size(tex_width);
			h = active_size(tex_height);
			pick = $urandom_range(0, 99);
			if (pick < 22)
				send_write(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
					pick_intensity(), pick_intensity(), pick_intensity());
			else if (pick < 30)	// anywhere, often beyond the size in use
				send_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					pick_intensity(), pick_intensity(), pick_intensity());
			else if (pick < 33) begin
				it = random_fields();
				it.cmd = CMD_UNUSED;
				send_item(it);
			end else if (pick < 66)
				send_fetch(tbs_pkg::CMD_NEAREST, pick_coord(), pick_coord());
			else
				send_fetch(tbs_pkg::CMD_BILINEAR, pick_coord(), pick_coord());
		end
	endtask

	// drop valid, wait for every outstanding result, then let the pipe settle;
	// at least one edge passes so valid is never raised again in the same step
	task automatic wait_drain(int settle);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_colors.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// valid is left high so writes can go back to back; cfg_close drops it
	task automatic cfg_write(logic [tbs_pkg::CFG_IDX_W-1:0] index,
			logic [tbs_pkg::SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (index == tbs_pkg::CFG_TEX_WIDTH)
			tex_width = data;
		else if (index == tbs_pkg::CFG_TEX_HEIGHT)
			tex_height = data;
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
	endtask

	// new size once idle; the spare indexes must change nothing
	task automatic set_size(logic [tbs_pkg::SIZE_W-1:0] w, logic [tbs_pkg::SIZE_W-1:0] h);
		wait_drain(SETTLE_CYCLES);
		cfg_write(tbs_pkg::CFG_TEX_WIDTH, w);
		cfg_write(CFG_SPARE_LO, 9'($urandom_range(0, 511)));
		cfg_write(tbs_pkg::CFG_TEX_HEIGHT, h);
		cfg_write(CFG_SPARE_HI, 9'($urandom_range(0, 511)));
		cfg_close();
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// full 256x256 after reset: saturating writes, corners, rounding,
	// coordinates at and above one, zero fractions and half weights
	task automatic test_directed_corners();
		tex_item_t it;
		send_write(0, 0, 0, 1023, 1024);
		send_write(255, 255, 4095, 4095, 4095);
		send_write(255, 0, 1, 2048, 3071);
		send_write(0, 255, 4095, 0, 512);
		send_fetch(tbs_pkg::CMD_NEAREST, 0, 0);
		send_fetch(tbs_pkg::CMD_NEAREST, 65536, 65536);	// rounds to 256, clamps to 255
		send_fetch(tbs_pkg::CMD_NEAREST, 131071, 0);
		send_fetch(tbs_pkg::CMD_NEAREST, 127, 128);	// just below and exactly half a texel
		send_fetch(tbs_pkg::CMD_BILINEAR, 0, 0);
		send_fetch(tbs_pkg::CMD_BILINEAR, 65535, 65535);	// right/lower neighbours clamp
		send_fetch(tbs_pkg::CMD_BILINEAR, 65536, 131071);
		send_fetch(tbs_pkg::CMD_BILINEAR, 256, 512);	// on a texel: zero fractions
		send_fetch(tbs_pkg::CMD_BILINEAR, 128, 65408);	// half weights
		it = random_fields();
		it.cmd = CMD_UNUSED;
		send_item(it);
		send_fetch(tbs_pkg::CMD_BILINEAR, 0, 65536);
	endtask

	// walk through sizes incl. 1x1, full, 0 and out-of-range register values
	task automatic test_size_settings();
		logic [tbs_pkg::SIZE_W-1:0] widths  [10] = '{1, 2, 3, 16, 256, 0, 300, 255, 7, 511};
		logic [tbs_pkg::SIZE_W-1:0] heights [10] = '{1, 2, 5, 16, 256, 511, 0, 256, 128, 4};
		for (int n = 0; n < 10; n++) begin
			set_size(widths[n], heights[n]);
			send_random_items(45);
		end
	endtask

	// receiver stops for a long stretch while fetches keep coming, so the
	// result queue fills and the input stalls
	task automatic test_output_backpressure();
		set_size(8, 8);
		hold_ticket++;
		for (int n = 0; n < 80; n++)
			send_fetch(($urandom_range(0, 3) == 0) ? tbs_pkg::CMD_NEAREST :
				tbs_pkg::CMD_BILINEAR, pick_coord(), pick_coord());
	endtask

	// sender goes quiet until everything is back, several times
	task automatic test_drain_pauses();
		set_size(20, 13);
		for (int n = 0; n < 5; n++) begin
			send_random_items(20);
			wait_drain(0);
		end
		send_random_items(5);
	endtask

	// neither side idles: words back to back, results taken every cycle
	task automatic test_no_idle_stretch();
		set_size(32, 32);
		no_idle = 1'b1;
		send_random_items(150);
		no_idle = 1'b0;
	endtask

	task automatic test_random_mix();
		set_size(256, 256);
		send_random_items(60);
		set_size(12, 9);
		send_random_items(60);
		set_size(64, 1);
		send_random_items(60);
	endtask

	// ---------------------------------------------------------------
	// receiver and checker
	// ---------------------------------------------------------------

	// ready drops at random, or for HOLD_CYCLES when a test asks
	always @(posedge clk) begin
		if (hold_ticket != hold_served) begin
			hold_served <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		$display("mismatch %s: got %h want %h (cycle %0d)", what, got, want,
			cycle_count);
	endtask

	// each result word against the oldest predicted color
	always @(posedge clk) begin
		logic [tbs_pkg::OUT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_colors.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata[15:0], '0);
			end else begin
				want = expected_colors.pop_front();
				if (m_axis_tdata[15:0] !== want[15:0])
					report_mismatch("red", m_axis_tdata[15:0], want[15:0]);
				if (m_axis_tdata[31:16] !== want[31:16])
					report_mismatch("green", m_axis_tdata[31:16], want[31:16]);
				if (m_axis_tdata[47:32] !== want[47:32])
					report_mismatch("blue", m_axis_tdata[47:32], want[47:32]);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_corners();
		test_size_settings();
		test_output_backpressure();
		test_drain_pauses();
		test_no_idle_stretch();
		test_random_mix();
		wait_drain(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
hdl/tbs_pkg.sv
hdl/tbs_ram.sv
hdl/tbs_blend.sv
hdl/texture_bilinear_sampler_unit.sv
bench/texture_bilinear_sampler_unit_tb.sv
